>>> rtl/minutiae_template_packer_core_macros.svh
// assertion macros for the minutiae template packer
`ifndef MINUTIAE_TEMPLATE_PACKER_CORE_MACROS_SVH
`define MINUTIAE_TEMPLATE_PACKER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge outside reset
`define MTP_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("packer assertion failed");
// antecedent implies consequent in the same cycle
`define MTP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("packer assertion failed");
`else
`define MTP_ASSERT_ALWAYS(lbl, expr)
`define MTP_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

>>> rtl/mtp_pkg.sv
package mtp_pkg;

    // template format
    localparam int TEMPLATE_BYTES = 512;
    localparam int MAX_RECORDS    = 76;
    localparam int POS_W          = 10;
    localparam int RL_W           = 7;
    localparam logic [7:0] MAGIC0 = 8'h43;
    localparam logic [7:0] MAGIC4 = 8'h01;
    localparam logic [POS_W-1:0] COUNT_OFFSET = POS_W'(19);
    localparam logic [POS_W-1:0] RECORD_START = POS_W'(31);

    // command sizing: low-bit byte plus four 3-byte records
    localparam int GROUP_SLOTS = 4;
    localparam int GROUP_BYTES = 3 * GROUP_SLOTS;
    localparam int CMD_BYTES   = GROUP_BYTES + 1;
    localparam int CNT_W       = $clog2(CMD_BYTES + 1);
    localparam int QUEUE_DEPTH = 4;

    // result item kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // one queued command: a run of output items with common kind
    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic [1:0]                kind;
        logic                      last_item;
    } cmd_t;

endpackage

>>> rtl/mtp_ifs.sv
// raw template byte channel
interface mtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_template;

    modport source (output valid, output data_byte, output end_of_template, input ready);
    modport sink   (input valid, input data_byte, input end_of_template, output ready);
endinterface

// packed result channel
interface mtp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] item_kind;
    logic       final_item;

    modport source (output valid, output out_byte, output item_kind, output final_item,
                    input ready);
    modport sink   (input valid, input out_byte, input item_kind, input final_item,
                    output ready);
endinterface

// command channel between front, queue and back
interface mtp_cmd_if
    import mtp_pkg::*;
;
    logic valid;
    logic ready;
    cmd_t cmd;

    modport source (output valid, output cmd, input ready);
    modport sink   (input valid, input cmd, output ready);
endinterface

>>> rtl/mtp_front.sv
module mtp_front
    import mtp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mtp_in_if.sink       raw_ch,
    mtp_cmd_if.source    cmd_ch
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(TEMPLATE_BYTES - 1);
    localparam logic [POS_W-1:0] POS_MAX  = '1;
    localparam logic [7:0]       MAX_REC_B = 8'(MAX_RECORDS);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             rej_reg, rej_next;
    logic [7:0]       low_reg, low_next;
    logic [RL_W-1:0]  rl_reg, rl_next;
    logic [2:0]       slot_reg, slot_next;
    logic [2:0][7:0]  hdr_reg;
    logic [GROUP_BYTES-1:0][7:0] grp_reg;

    logic             accept;
    logic             rej_v;
    logic             bad;
    logic             hdr_we;
    logic [1:0]       hdr_idx;
    logic             grp_we;
    logic [3:0]       grp_idx;
    logic [1:0]       s;
    logic [1:0]       k;
    logic [7:0]       low_new;
    logic [2:0]       slot_new;
    logic [7:0]       cnt_b;
    logic [7:0]       b;

    assign b      = raw_ch.data_byte;
    assign accept = raw_ch.valid && raw_ch.ready;
    assign raw_ch.ready = cmd_ch.ready;

    // slot and byte-in-record of the current position
    assign s       = slot_reg[1:0];
    assign k       = 2'(pos_reg - RECORD_START);
    assign hdr_idx = 2'(pos_reg - POS_W'(1));
    assign grp_idx = 4'({2'b00, s} * 4'd3) + {2'b00, k};
    assign low_new = low_reg | ({6'b000000, b[1:0]} << {s, 1'b0});
    assign slot_new = {1'b0, s} + 3'd1;
    assign cnt_b   = (b > MAX_REC_B) ? MAX_REC_B : b;
    assign bad     = rej_reg || (pos_reg != LAST_POS) || (rl_reg != '0);

    // classify the accepted byte and build its command
    always_comb
    begin
        pos_next   = pos_reg;
        rej_next   = rej_reg;
        low_next   = low_reg;
        rl_next    = rl_reg;
        slot_next  = slot_reg;
        hdr_we     = 1'b0;
        grp_we     = 1'b0;
        rej_v      = rej_reg | (pos_reg >= LAST_POS);
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd   = '0;
        if (accept)
        begin
            if (raw_ch.end_of_template)
            begin
                cmd_ch.valid          = 1'b1;
                cmd_ch.cmd.count      = CNT_W'(1);
                cmd_ch.cmd.kind       = bad ? KIND_REJECT : KIND_ACCEPT;
                cmd_ch.cmd.last_item  = 1'b1;
                pos_next  = '0;
                rej_next  = 1'b0;
                low_next  = '0;
                rl_next   = '0;
                slot_next = '0;
            end
            else
            begin
                rej_next = rej_v;
                if (!rej_v)
                begin
                    if (pos_reg == POS_W'(0))
                    begin
                        if (b != MAGIC0)
                            rej_next = 1'b1;
                    end
                    else if (pos_reg <= POS_W'(3))
                    begin
                        hdr_we = 1'b1;
                    end
                    else if (pos_reg == POS_W'(4))
                    begin
                        if (b != MAGIC4)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            cmd_ch.valid          = 1'b1;
                            cmd_ch.cmd.bytes[0]   = hdr_reg[0];
                            cmd_ch.cmd.bytes[1]   = hdr_reg[1];
                            cmd_ch.cmd.bytes[2]   = hdr_reg[2];
                            cmd_ch.cmd.count      = CNT_W'(3);
                            cmd_ch.cmd.kind       = KIND_BYTE;
                        end
                    end
                    else if (pos_reg == POS_W'(5) || pos_reg == POS_W'(6))
                    begin
                        cmd_ch.valid        = 1'b1;
                        cmd_ch.cmd.bytes[0] = b;
                        cmd_ch.cmd.count    = CNT_W'(1);
                        cmd_ch.cmd.kind     = KIND_BYTE;
                    end
                    else if (pos_reg == COUNT_OFFSET)
                    begin
                        cmd_ch.valid        = 1'b1;
                        cmd_ch.cmd.bytes[0] = cnt_b;
                        cmd_ch.cmd.count    = CNT_W'(1);
                        cmd_ch.cmd.kind     = KIND_BYTE;
                        rl_next   = RL_W'(cnt_b);
                        low_next  = '0;
                        slot_next = '0;
                    end
                    else if (pos_reg >= RECORD_START && rl_reg != '0)
                    begin
                        if (k != 2'd3)
                        begin
                            grp_we = 1'b1;
                        end
                        else
                        begin
                            low_next  = low_new;
                            slot_next = slot_new;
                            rl_next   = rl_reg - RL_W'(1);
                            // group complete or last counted record
                            if (slot_new == 3'(GROUP_SLOTS) || rl_reg == RL_W'(1))
                            begin
                                cmd_ch.valid        = 1'b1;
                                cmd_ch.cmd.bytes[0] = low_new;
                                for (int j = 0; j < GROUP_BYTES; j++)
                                    cmd_ch.cmd.bytes[j+1] = grp_reg[j];
                                cmd_ch.cmd.count = CNT_W'(1)
                                    + CNT_W'({2'b00, slot_new} * 5'd3);
                                cmd_ch.cmd.kind  = KIND_BYTE;
                                low_next  = '0;
                                slot_next = '0;
                            end
                        end
                    end
                end
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    // template control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            rej_reg  <= 1'b0;
            low_reg  <= '0;
            rl_reg   <= '0;
            slot_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            rej_reg  <= rej_next;
            low_reg  <= low_next;
            rl_reg   <= rl_next;
            slot_reg <= slot_next;
        end
    end

    // held header and record bytes
    always_ff @(posedge clk)
    begin
        if (hdr_we)
            hdr_reg[hdr_idx] <= b;
        if (grp_we)
            grp_reg[grp_idx] <= b;
    end

endmodule

>>> rtl/mtp_queue.sv
module mtp_queue
    import mtp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mtp_cmd_if.sink      wr_ch,
    mtp_cmd_if.source    rd_ch
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push;
    logic              pop;

    assign wr_ch.ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign rd_ch.valid = (fill_reg != '0);
    assign rd_ch.cmd   = mem_reg[rd_ptr_reg];
    assign push = wr_ch.valid && wr_ch.ready;
    assign pop  = rd_ch.valid && rd_ch.ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            fill_next = fill_reg + FILL_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - FILL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // command storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_ch.cmd;
    end

endmodule

>>> rtl/mtp_back.sv
module mtp_back
    import mtp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mtp_cmd_if.sink      cmd_ch,
    mtp_out_if.source    pack_ch
);

    cmd_t             cur_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             busy_reg, busy_next;
    logic             xfer;
    logic             at_end;
    logic             load;

    assign xfer   = pack_ch.valid && pack_ch.ready;
    assign at_end = (idx_reg == cur_reg.count - CNT_W'(1));
    assign cmd_ch.ready = !busy_reg || (xfer && at_end);
    assign load   = cmd_ch.valid && cmd_ch.ready;

    // current item of the running command
    assign pack_ch.valid      = busy_reg;
    assign pack_ch.out_byte   = cur_reg.bytes[idx_reg];
    assign pack_ch.item_kind  = cur_reg.kind;
    assign pack_ch.final_item = cur_reg.last_item;

    // step through items, reload from the queue without a gap
    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (xfer)
        begin
            if (at_end)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= cmd_ch.cmd;
    end

endmodule

>>> rtl/minutiae_template_packer_core.sv
// Minutiae template packer: takes a 512-byte template one byte per transfer
// and emits its packed form (header bytes 1-3 and 5-6, capped record count,
// and per group of up to four records one low-bit byte then 3 bytes per
// record), closed by one status item that says accepted or rejected. Input
// is taken at one byte per cycle while the four-entry command queue has room;
// the output side drains one item per cycle while pack_ch is ready, sending a
// full record group (13 items) from the back end's command register. Packed
// bytes already sent are not withdrawn when a template is later rejected.
`include "minutiae_template_packer_core_macros.svh"

module minutiae_template_packer_core
    import mtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mtp_in_if.sink      raw_ch,
    mtp_out_if.source   pack_ch
);

    mtp_cmd_if front_cmd ();
    mtp_cmd_if back_cmd ();

    logic end_xfer;
    logic front_status;
    logic back_status;
    logic count_ok;
    logic status_kind;

    // classify input bytes into commands
    mtp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .raw_ch (raw_ch),
        .cmd_ch (front_cmd.source)
    );

    // decoupling queue
    mtp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_ch (front_cmd.sink),
        .rd_ch (back_cmd.source)
    );

    // expand commands into result items
    mtp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_ch  (back_cmd.sink),
        .pack_ch (pack_ch)
    );

    // terms for the checks
    assign end_xfer     = raw_ch.valid && raw_ch.ready && raw_ch.end_of_template;
    assign front_status = front_cmd.valid && front_cmd.cmd.last_item;
    assign back_status  = back_cmd.valid && back_cmd.cmd.last_item;
    assign count_ok     = (back_cmd.cmd.count != '0)
                          && (back_cmd.cmd.count <= CNT_W'(CMD_BYTES));
    assign status_kind  = (pack_ch.item_kind != KIND_BYTE);

    // checks
    `MTP_ASSERT_IMPLY(a_end_makes_status, end_xfer, front_status)
    `MTP_ASSERT_IMPLY(a_status_single, back_status, back_cmd.cmd.count == CNT_W'(1))
    `MTP_ASSERT_IMPLY(a_count_range, back_cmd.valid, count_ok)
    `MTP_ASSERT_IMPLY(a_final_kind, pack_ch.valid, pack_ch.final_item == status_kind)

endmodule
